// ===== rtl/nse_pkg.sv =====
// nse_pkg: shared types and constants for the NURBS surface evaluator.
// No dependencies.
package nse_pkg;
	localparam int DEGREE_DEF = 3;
	localparam int NUM_U_DEF  = 4;
	localparam int NUM_V_DEF  = 4;
	localparam int ONE_Q16    = 65536;

	typedef enum logic [1:0] {
		KIND_CTRL  = 2'd0,
		KIND_UKNOT = 2'd1,
		KIND_VKNOT = 2'd2,
		KIND_EVAL  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B0,
		ST_BRD,
		ST_BMUL,
		ST_BDIV,
		ST_BWR,
		ST_PRD,
		ST_PMUL,
		ST_PW,
		ST_CRD,
		ST_CDIV,
		ST_CMUL,
		ST_DONE
	} state_t;

	// control from sequencer to divider
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;
endpackage

// ===== rtl/nse_div.sv =====
// nse_div: iterative unsigned restoring divider, one quotient bit a cycle.
// Depends on nse_pkg.
module nse_div import nse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] quo_q, rem_q, den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

// ===== rtl/nurbs_surface_eval.sv =====
// nurbs_surface_eval: top level, stores and sequencer around a shared divider.
// Depends on nse_pkg and nse_div.
//
//  channel | signals                                          | dir
//  item    | start, busy (out), kind, slot, coord_*, weight,
//          | knot_value, u_param, v_param                     | in
//  result  | done, point_x/y/z, degenerate                    | out
//
// Load items are written straight into the stores and leave the sequencer idle.
// An evaluate item runs Cox-de Boor over both knot vectors, then the weighted
// products and one coefficient per point. Each basis term with a nonzero
// denominator and, for a nonzero weight sum, each coefficient go through the
// shared divider. Each basis value adds a write state; products use PRD/PMUL/PW.
// Reset clears the sequencer only; stores hold garbage until written.
// The result is strobed on done for one cycle; nothing can stall it.
module nurbs_surface_eval import nse_pkg::*; #(
	parameter int DEGREE = DEGREE_DEF,
	parameter int NUM_U  = NUM_U_DEF,
	parameter int NUM_V  = NUM_V_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [3:0]         slot,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [31:0]        weight,
	input  logic [16:0]        knot_value,
	input  logic [16:0]        u_param,
	input  logic [16:0]        v_param,
	output logic               done,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic               degenerate
);
	localparam int NPTS = NUM_U * NUM_V;
	localparam int KU   = NUM_U + DEGREE + 1;
	localparam int KV   = NUM_V + DEGREE + 1;
	localparam int KMAX = (KU > KV) ? KU : KV;
	localparam int PW   = $clog2(NPTS);
	localparam int KW   = $clog2(KMAX);
	localparam int DW   = $clog2(DEGREE + 1);
	localparam int UW   = $clog2(NUM_U);
	localparam int VW   = $clog2(NUM_V);

	logic [31:0] mem_x [NPTS];
	logic [31:0] mem_y [NPTS];
	logic [31:0] mem_z [NPTS];
	logic [31:0] mem_w [NPTS];
	logic [16:0] uk [KU];
	logic [16:0] vk [KV];

	state_t st_q, st_d;
	logic        dir_q;      // 0: u basis, 1: v basis
	logic [DW-1:0] lvl_q;
	logic [KW-1:0] idx_q;
	logic        term_q;     // 0: A term, 1: B term
	logic [PW-1:0] pt_q;
	logic [UW-1:0] pu_q;
	logic [VW-1:0] pv_q;
	logic [16:0] tu_q, tv_q;
	logic [16:0] cur_q [KMAX];
	logic [16:0] nxt_q [KMAX];
	logic [16:0] nu_q [NUM_U];
	logic [16:0] nv_q [NUM_V];
	logic [48:0] bw_q [NPTS];
	logic [52:0] den_q;
	logic signed [63:0] sx_q, sy_q, sz_q;
	logic signed [35:0] acc_q;
	logic signed [18:0] dena_q;
	logic        neg_q;
	logic [33:0] b_q;
	logic [16:0] c_q;
	logic [31:0] px_q, py_q, pz_q;
	div_req_t dreq;
	div_rsp_t drsp;

	nse_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [16:0] kn_a, kn_b, tt;
	logic [KW-1:0] ia, ib;
	logic signed [35:0] prod;
	logic [35:0] mag;
	logic [17:0] dmag;
	logic signed [35:0] qs, sum;
	logic [16:0] klv;
	logic signed [49:0] cx, cy, cz;

	function automatic logic [16:0] kread(input logic d, input logic [KW-1:0] i,
		input logic [16:0] a [KU], input logic [16:0] b [KV]);
		logic [16:0] r;
		r = d ? b[i] : a[i];
		return r;
	endfunction

	function automatic logic [31:0] fin(input logic signed [63:0] s);
		logic signed [47:0] v;
		v = 48'(s >>> 16);
		if (v > 48'sd2147483647) return 32'h7fffffff;
		if (v < -48'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	// term A uses k[i], k[i+n]; term B uses k[i+1], k[i+n+1]
	always_comb begin
		ia = term_q ? idx_q + KW'(1) : idx_q;
		ib = ia + KW'(lvl_q);
		kn_a = kread(dir_q, ia, uk, vk);
		kn_b = kread(dir_q, ib, uk, vk);
		tt = dir_q ? tv_q : tu_q;
		klv = term_q ? cur_q[idx_q + KW'(1)] : cur_q[idx_q];
		prod = (term_q ? ($signed({2'b0, kn_b}) - $signed({2'b0, tt}))
		               : ($signed({2'b0, tt}) - $signed({2'b0, kn_a})))
		       * $signed({19'b0, klv});
		mag = prod[35] ? 36'(-prod) : 36'(prod);
		dmag = dena_q[18] ? 18'(-dena_q) : dena_q[17:0];
		qs = neg_q ? -$signed(36'(drsp.quo[33:0])) : $signed(36'(drsp.quo[33:0]));
		sum = acc_q + qs;
		cx = $signed({1'b0, c_q}) * $signed(mem_x[pt_q]);
		cy = $signed({1'b0, c_q}) * $signed(mem_y[pt_q]);
		cz = $signed({1'b0, c_q}) * $signed(mem_z[pt_q]);
	end

	function automatic logic [KW-1:0] last_idx(input logic d, input logic [DW-1:0] n);
		return d ? KW'(KV - 2 - int'(n)) : KW'(KU - 2 - int'(n));
	endfunction

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (start && kind == KIND_EVAL) st_d = ST_B0;
			ST_B0:   st_d = (DEGREE == 0) ? ST_PRD : ST_BRD;
			ST_BRD:  st_d = ST_BMUL;
			ST_BMUL: st_d = ST_BDIV;
			ST_BDIV: if (drsp.done || dena_q == 0) st_d = term_q ? ST_BWR : ST_BRD;
			ST_BWR:  if (idx_q == last_idx(dir_q, lvl_q) && lvl_q == DW'(DEGREE)
			              && dir_q) st_d = ST_PRD;
			         else st_d = ST_BRD;
			ST_PRD:  st_d = ST_PMUL;
			ST_PMUL: st_d = ST_PW;
			ST_PW:   st_d = (pt_q == PW'(NPTS - 1)) ? ST_CRD : ST_PRD;
			ST_CRD:  st_d = (den_q == 0) ? ST_DONE : ST_CDIV;
			ST_CDIV: if (drsp.done) st_d = ST_CMUL;
			ST_CMUL: st_d = (pt_q == PW'(NPTS - 1)) ? ST_DONE : ST_CRD;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	assign busy = (st_q != ST_IDLE);

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = 64'(mag);
		dreq.den = 64'(dmag);
		if (st_q == ST_BMUL && dena_q != 0) dreq.start = 1'b1;
		if (st_q == ST_CRD && den_q != 0) begin
			dreq.start = 1'b1;
			dreq.num = {bw_q[pt_q][47:0], 16'b0};
			dreq.den = 64'(den_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= (st_q == ST_DONE);
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			case (kind)
				KIND_CTRL: if (32'(slot) < NPTS) begin
					mem_x[PW'(slot)] <= coord_x;
					mem_y[PW'(slot)] <= coord_y;
					mem_z[PW'(slot)] <= coord_z;
					mem_w[PW'(slot)] <= weight;
				end
				KIND_UKNOT: if (32'(slot) < KU) uk[KW'(slot)] <= knot_value;
				KIND_VKNOT: if (32'(slot) < KV) vk[KW'(slot)] <= knot_value;
				default: begin
					tu_q <= u_param;
					tv_q <= v_param;
					dir_q <= 1'b0;
				end
			endcase
		end
		case (st_q)
			ST_B0: begin
				for (int i = 0; i < KMAX - 1; i++)
					cur_q[i] <= (i < KU - 1 && uk[i] <= tu_q && tu_q < uk[i + 1])
						? 17'(ONE_Q16) : 17'd0;
				lvl_q <= DW'(1); idx_q <= '0; term_q <= 1'b0; acc_q <= '0;
			end
			ST_BRD: begin
				dena_q <= $signed({2'b0, kn_b}) - $signed({2'b0, kn_a});
			end
			ST_BMUL: neg_q <= prod[35] ^ dena_q[18];
			ST_BDIV: if (drsp.done || dena_q == 0) begin
				if (drsp.done) acc_q <= sum;
				term_q <= ~term_q;
			end
			ST_BWR: begin
				nxt_q[idx_q] <= (acc_q < 0) ? 17'd0 :
					(acc_q > 36'sd65536) ? 17'(ONE_Q16) : acc_q[16:0];
				acc_q <= '0;
				if (idx_q == last_idx(dir_q, lvl_q)) begin
					idx_q <= '0;
					if (lvl_q == DW'(DEGREE)) begin
						if (!dir_q) begin
							for (int i = 0; i < NUM_U; i++)
								nu_q[i] <= (i == int'(idx_q)) ? ((acc_q < 0) ? 17'd0 :
									(acc_q > 36'sd65536) ? 17'(ONE_Q16) : acc_q[16:0])
									: nxt_q[i];
							dir_q <= 1'b1;
							lvl_q <= DW'(1);
							for (int i = 0; i < KMAX - 1; i++)
								cur_q[i] <= (i < KV - 1 && vk[i] <= tv_q && tv_q < vk[i + 1])
									? 17'(ONE_Q16) : 17'd0;
						end else begin
							for (int i = 0; i < NUM_V; i++)
								nv_q[i] <= (i == int'(idx_q)) ? ((acc_q < 0) ? 17'd0 :
									(acc_q > 36'sd65536) ? 17'(ONE_Q16) : acc_q[16:0])
									: nxt_q[i];
							pt_q <= '0; den_q <= '0;
							pu_q <= '0; pv_q <= '0;
						end
					end else begin
						lvl_q <= lvl_q + DW'(1);
						for (int i = 0; i < KMAX; i++)
							cur_q[i] <= (i == int'(idx_q)) ? ((acc_q < 0) ? 17'd0 :
								(acc_q > 36'sd65536) ? 17'(ONE_Q16) : acc_q[16:0])
								: nxt_q[i];
					end
				end else idx_q <= idx_q + KW'(1);
			end
			ST_PRD: b_q <= nu_q[pu_q] * nv_q[pv_q];
			ST_PMUL: bw_q[pt_q] <= 49'(b_q[33:16]) * 49'(mem_w[pt_q]);
			ST_PW: begin
				den_q <= den_q + 53'(bw_q[pt_q]);
				if (pu_q == UW'(NUM_U - 1)) begin
					pu_q <= '0;
					pv_q <= pv_q + VW'(1);
				end else pu_q <= pu_q + UW'(1);
				if (pt_q == PW'(NPTS - 1)) begin
					pt_q <= '0; sx_q <= '0; sy_q <= '0; sz_q <= '0;
				end else pt_q <= pt_q + PW'(1);
			end
			ST_CDIV: if (drsp.done)
				c_q <= (53'(bw_q[pt_q]) >= den_q) ? 17'(ONE_Q16) : drsp.quo[16:0];
			ST_CMUL: begin
				sx_q <= sx_q + 64'(cx);
				sy_q <= sy_q + 64'(cy);
				sz_q <= sz_q + 64'(cz);
				pt_q <= pt_q + PW'(1);
			end
			ST_DONE: begin
				px_q <= (den_q == 0) ? 32'd0 : fin(sx_q);
				py_q <= (den_q == 0) ? 32'd0 : fin(sy_q);
				pz_q <= (den_q == 0) ? 32'd0 : fin(sz_q);
				degenerate <= (den_q == 0);
			end
			default: ;
		endcase
	end

	assign point_x = px_q;
	assign point_y = py_q;
	assign point_z = pz_q;
endmodule

// ===== test/tb_nurbs_surface_eval.sv =====
// tb_nurbs_surface_eval: self-checking bench for the NURBS surface evaluator.
// Depends on nse_pkg and the nurbs_surface_eval RTL. Items are queued by an
// initial block, driven and predicted at acceptance, and results are checked in order.
module tb_nurbs_surface_eval;
	import nse_pkg::*;

	localparam int DEG   = 3;
	localparam int NU    = 4;
	localparam int NV    = 4;
	localparam int NPTS  = NU * NV;
	localparam int NKNOT = NU + DEG + 1;
	localparam int N_ITEMS = 1300;
	localparam longint CYCLE_LIMIT = 40000000;

	typedef struct {
		kind_t       kind;
		logic [3:0]  slot;
		logic [31:0] x, y, z, w;
		logic [16:0] knot, u, v;
		bit          drain;
		bit          calm;
	} job_t;

	typedef struct {
		logic [31:0] x, y, z;
		logic        degen;
	} point_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] kind = '0;
	logic [3:0] slot = '0;
	logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic [31:0] weight = '0;
	logic [16:0] knot_value = '0, u_param = '0, v_param = '0;
	logic done;
	logic signed [31:0] point_x, point_y, point_z;
	logic degenerate;

	job_t   pending_items[$];
	point_t expected_points[$];
	int     fail_count = 0;
	int     gap = 0;
	int     queued = 0;
	longint cycles = 0;
	bit     calm_phase = 0;

	// shadow stores of the block
	logic [31:0] px[NPTS], py[NPTS], pz[NPTS], pw[NPTS];
	logic [16:0] uk[NKNOT], vk[NKNOT];

	// knot values as queued, for picking parameters on knots
	logic [16:0] uk_now[NKNOT], vk_now[NKNOT];

	nurbs_surface_eval #(.DEGREE(DEG), .NUM_U(NU), .NUM_V(NV)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.slot(slot), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.weight(weight), .knot_value(knot_value), .u_param(u_param),
		.v_param(v_param), .done(done), .point_x(point_x), .point_y(point_y),
		.point_z(point_z), .degenerate(degenerate)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Cox-de Boor with clamp, first four basis values
	function automatic void cox_de_boor(input logic [16:0] kn[NKNOT], input longint t,
			output longint res[4]);
		longint cur[NKNOT];
		longint nxt[NKNOT];
		longint s, d1, d2;
		for (int i = 0; i < NKNOT - 1; i++)
			cur[i] = (kn[i] <= t && t < kn[i+1]) ? 65536 : 0;
		for (int n = 1; n <= DEG; n++) begin
			for (int i = 0; i < NKNOT - 1 - n; i++) begin
				s = 0;
				d1 = longint'(kn[i+n]) - longint'(kn[i]);
				d2 = longint'(kn[i+n+1]) - longint'(kn[i+1]);
				if (d1 != 0)
					s += ((t - longint'(kn[i])) * cur[i]) / d1;
				if (d2 != 0)
					s += ((longint'(kn[i+n+1]) - t) * cur[i+1]) / d2;
				if (s < 0)
					s = 0;
				if (s > 65536)
					s = 65536;
				nxt[i] = s;
			end
			for (int i = 0; i < NKNOT - 1 - n; i++)
				cur[i] = nxt[i];
		end
		for (int i = 0; i < 4; i++)
			res[i] = cur[i];
	endfunction

	function automatic logic [31:0] floor_sat(input longint s);
		longint q;
		if (s >= 0)
			q = s / 65536;
		else
			q = -((-s + 65535) / 65536);
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic point_t surface_point(input logic [16:0] u, input logic [16:0] v);
		longint nu[4], nv[4];
		logic [63:0] bw[NPTS];
		logic [127:0] den, num;
		longint c, sx, sy, sz;
		point_t r;
		cox_de_boor(uk, longint'(u), nu);
		cox_de_boor(vk, longint'(v), nv);
		den = 0;
		for (int q = 0; q < NV; q++)
			for (int p = 0; p < NU; p++) begin
				bw[q*NU+p] = ((nu[p] * nv[q]) >>> 16) * longint'({32'd0, pw[q*NU+p]});
				den += bw[q*NU+p];
			end
		r = '{x: 0, y: 0, z: 0, degen: 1'b1};
		if (den == 0)
			return r;
		sx = 0; sy = 0; sz = 0;
		for (int p = 0; p < NPTS; p++) begin
			num = bw[p];
			if (num >= den)
				c = 65536;
			else
				c = longint'((num << 16) / den);
			sx += c * longint'(signed'(px[p]));
			sy += c * longint'(signed'(py[p]));
			sz += c * longint'(signed'(pz[p]));
		end
		r = '{x: floor_sat(sx), y: floor_sat(sy), z: floor_sat(sz), degen: 1'b0};
		return r;
	endfunction

	task automatic apply_item(input job_t j);
		case (j.kind)
			KIND_CTRL: begin
				px[j.slot] = j.x; py[j.slot] = j.y; pz[j.slot] = j.z; pw[j.slot] = j.w;
			end
			KIND_UKNOT: if (j.slot < NKNOT) uk[j.slot] = j.knot;
			KIND_VKNOT: if (j.slot < NKNOT) vk[j.slot] = j.knot;
			KIND_EVAL: expected_points.push_back(surface_point(j.u, j.v));
			default: ;
		endcase
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		job_t j;
		logic nxt_start;
		if (!arst_n) begin
			start <= 1'b0;
			gap = 0;
		end else begin
			nxt_start = start;
			if (start && !busy) begin
				j = pending_items.pop_front();
				apply_item(j);
				nxt_start = 1'b0;
				if (!j.calm && $urandom_range(0, 3) == 0)
					gap = $urandom_range(1, 5);
			end
			if (!nxt_start) begin
				if (gap > 0)
					gap--;
				else if (pending_items.size() > 0) begin
					if (pending_items[0].drain) begin
						if (expected_points.size() == 0)
							void'(pending_items.pop_front());
					end else begin
						j = pending_items[0];
						kind <= j.kind; slot <= j.slot;
						coord_x <= j.x; coord_y <= j.y; coord_z <= j.z; weight <= j.w;
						knot_value <= j.knot; u_param <= j.u; v_param <= j.v;
						nxt_start = 1'b1;
					end
				end
			end
			start <= nxt_start;
		end
	end

	// monitor
	always @(posedge clk) begin
		point_t e;
		if (arst_n && done) begin
			if (expected_points.size() == 0) begin
				$error("result with no evaluate item outstanding");
				fail_count++;
			end else begin
				e = expected_points.pop_front();
				if (point_x !== e.x) begin
					$error("point_x expected %h got %h", e.x, point_x); fail_count++;
				end
				if (point_y !== e.y) begin
					$error("point_y expected %h got %h", e.y, point_y); fail_count++;
				end
				if (point_z !== e.z) begin
					$error("point_z expected %h got %h", e.z, point_z); fail_count++;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate expected %b got %b", e.degen, degenerate);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL nurbs_surface_eval");
			$finish;
		end
	end

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] rnd_q1();
		case ($urandom_range(0, 4))
			0: return 17'd0;
			1: return 17'd65536;
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// unused fields carry random values so every input bit toggles
	task automatic put(input kind_t k, input int s, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] w, input logic [16:0] kv,
			input logic [16:0] u, input logic [16:0] v);
		job_t j;
		j = '{kind: k, slot: 4'(s), x: x, y: y, z: z, w: w, knot: kv, u: u, v: v,
			drain: 0, calm: calm_phase};
		pending_items.push_back(j);
		queued++;
	endtask

	task automatic put_ctrl(input int s, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] w);
		put(KIND_CTRL, s, x, y, z, w, rnd_q1(), rnd_q1(), rnd_q1());
	endtask

	task automatic put_knot(input kind_t k, input int s, input logic [16:0] kv);
		put(k, s, $urandom, $urandom, $urandom, $urandom, kv, rnd_q1(), rnd_q1());
	endtask

	task automatic put_eval(input logic [16:0] u, input logic [16:0] v);
		put(KIND_EVAL, $urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
			rnd_q1(), u, v);
	endtask

	task automatic put_drain();
		job_t j;
		j = '{kind: KIND_EVAL, slot: 0, x: 0, y: 0, z: 0, w: 0, knot: 0, u: 0, v: 0,
			drain: 1, calm: 1};
		pending_items.push_back(j);
	endtask

	// knot vector: clamped, random sorted, or unsorted
	task automatic put_knot_vector(input kind_t k);
		logic [16:0] kv[$];
		int style;
		style = $urandom_range(0, 9);
		for (int i = 0; i < NKNOT; i++)
			kv.push_back(rnd_q1());
		if (style < 3) begin
			for (int i = 0; i < NKNOT; i++)
				kv[i] = (i < 4) ? 17'd0 : 17'd65536;
			kv[4 - $urandom_range(0, 1)] = 17'($urandom_range(1, 65535));
			kv.sort();
		end else if (style < 9)
			kv.sort();
		for (int i = 0; i < NKNOT; i++)
			put_knot(k, i, kv[i]);
	endtask

	function automatic logic [16:0] pick_param(input kind_t k);
		case ($urandom_range(0, 3))
			0: return (k == KIND_UKNOT) ? uk_now[$urandom_range(0, NKNOT-1)]
				: vk_now[$urandom_range(0, NKNOT-1)];
			1: return rnd_q1();
			default: return 17'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic track_knots();
		foreach (pending_items[i]) begin
			if (pending_items[i].kind == KIND_UKNOT && pending_items[i].slot < NKNOT)
				uk_now[pending_items[i].slot] = pending_items[i].knot;
			if (pending_items[i].kind == KIND_VKNOT && pending_items[i].slot < NKNOT)
				vk_now[pending_items[i].slot] = pending_items[i].knot;
		end
	endtask

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// every store entry written before the first evaluation
		for (int i = 0; i < NPTS; i++)
			put_ctrl(i, (i % 2) ? 32'h7fffffff : 32'h80000000, $urandom,
				32'(i) << 16, (i == 5) ? 32'hffffffff : (i == 6) ? 32'h0 : 32'h00010000);
		for (int i = 0; i < NKNOT; i++) begin
			put_knot(KIND_UKNOT, i, (i < 4) ? 17'd0 : 17'd65536);
			put_knot(KIND_VKNOT, i, (i < 4) ? 17'd0 : 17'd65536);
		end
		put_eval(17'd0, 17'd0);
		put_eval(17'd65536, 17'd65536);   // last knot: degenerate
		put_eval(17'd32768, 17'd65535);
		put_eval(17'd65535, 17'd0);
		// out of range knot slots are ignored
		put_knot(KIND_UKNOT, 15, 17'd12345);
		put_knot(KIND_VKNOT, 8, 17'd999);
		// decreasing knots
		for (int i = 0; i < NKNOT; i++)
			put_knot(KIND_UKNOT, i, 17'(65536 - i * 8000));
		put_eval(17'd30000, 17'd20000);
		put_drain();
		// knots end short of the parameter
		for (int i = 0; i < NKNOT; i++)
			put_knot(KIND_UKNOT, i, 17'(i * 4000));
		put_eval(17'd65536, 17'd40000);
		put_eval(17'd10000, 17'd40000);

		while (queued < N_ITEMS) begin
			track_knots();
			calm_phase = (queued > N_ITEMS - 150);
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 1)) put_knot_vector(KIND_UKNOT);
				if ($urandom_range(0, 1)) put_knot_vector(KIND_VKNOT);
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++)
					put_ctrl($urandom_range(0, 15), rnd_word(), rnd_word(), rnd_word(),
						($urandom_range(0, 3) == 0) ? rnd_word()
						: 32'($urandom_range(1, 32'h00040000)));
				track_knots();
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					put_eval(pick_param(KIND_UKNOT), pick_param(KIND_VKNOT));
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					case ($urandom_range(0, 2))
						0: put_ctrl($urandom_range(0, 15), rnd_word(), rnd_word(),
							rnd_word(), rnd_word());
						1: put_knot(KIND_UKNOT, $urandom_range(0, 15), rnd_q1());
						default: put_knot(KIND_VKNOT, $urandom_range(0, 15), rnd_q1());
					endcase
				put_eval(rnd_q1(), rnd_q1());
			end
			if ($urandom_range(0, 40) == 0)
				put_drain();
		end

		while (pending_items.size() > 0 || start || expected_points.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("PASS nurbs_surface_eval");
		else
			$display("FAIL nurbs_surface_eval");
		$finish;
	end
endmodule

// ===== nurbs_surface_eval.f =====
rtl/nse_pkg.sv
rtl/nse_div.sv
rtl/nurbs_surface_eval.sv
test/tb_nurbs_surface_eval.sv
